FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/core/clzss_pkg.sv
// ----------------------------------------------------------------------------
// clzss_pkg
// Types and constants of the context LZSS decompressor.
// ----------------------------------------------------------------------------
package clzss_pkg;

  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned TOKEN_W  = 9;
  localparam int unsigned BUF_W    = 16;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned POS_W    = 32;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOOKUP = 6'b000010,
    ST_DECODE = 6'b000100,
    ST_HREAD  = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_UPDATE = 6'b100000
  } state_t;

endpackage

FILE: rtl/core/context_lzss_decompressor_unit.sv
// ----------------------------------------------------------------------------
// context_lzss_decompressor_unit
// Context LZSS decompressor: 9-bit tokens in, decompressed bytes out.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one compressed byte per transaction;
// in_first restarts the stream and clears the slot tables, counters and
// history before the byte is taken. Output channel out_valid/out_ready carries
// one decompressed byte per transaction, with out_last on the final byte of an
// input byte and out_done on the byte that reaches output_size.
// cfg_wr_en/cfg_wr_data write output_size (reset value 1); the user must write
// it only while idle, since the block does not enforce this. One input byte
// is processed at a time. A literal passes the lookup, decode, emit and
// update states; a copy of up to 8 bytes passes lookup and decode, then one
// history read and one history write per copied byte; a token that reaches
// output_size skips the final table update state. The first output byte is
// registered in the emit state, after the history read state for a copy.
// Reset clears all control state at once; no memory sweep is needed, since
// table rows carry valid bits and unwritten history is never read.
// A stalled receiver holds the output register and freezes the copy loop;
// the next input byte is accepted once the previous token is retired, even
// while its last byte waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module context_lzss_decompressor_unit #(
  parameter int unsigned HISTORY_DEPTH = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_done
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] PTR_MAX = AW'(HISTORY_DEPTH - 1);

  clzss_pkg::state_t state;

  logic [31:0] output_size;
  logic [15:0] bit_buffer;
  logic [4:0]  bit_count;
  logic [31:0] out_position;
  logic [7:0]  previous_byte;
  logic        finished;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] start_ptr;
  logic [8:0]  token;
  logic [2:0]  len_m1;
  logic [2:0]  idx;
  logic        zero_src;
  logic [4:0]  ctr;
  logic        wrapped;
  logic [7:0]  last_b;
  logic [255:0] row_valid;

  logic [5:0]    ctr_mem [256];
  logic [AW-1:0] seq_mem [8192];
  logic [7:0]    hist_mem [HISTORY_DEPTH];
  logic [5:0]    ctr_rd;
  logic [AW-1:0] seq_rd;
  logic [7:0]    hist_rd;

  logic [15:0] base_buf;
  logic [4:0]  base_cnt;
  logic        base_fin;
  logic [15:0] buf_next;
  logic [4:0]  cnt_next;
  logic        in_fire;
  logic        emit_fire;
  logic [7:0]  emit_b;
  logic        emit_done;
  logic        emit_last;
  logic [4:0]  cur_ctr;
  logic        cur_wrapped;
  logic        slot_ok;

  assign in_ready  = (state == clzss_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign emit_fire = (state == clzss_pkg::ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    base_buf = in_first ? 16'd0 : bit_buffer;
    base_cnt = in_first ? 5'd0 : bit_count;
    base_fin = in_first ? 1'b0 : finished;
    buf_next = base_buf | 16'({8'd0, in_byte} << base_cnt[3:0]);
    cnt_next = base_cnt + 5'd8;
  end

  always_comb begin
    cur_ctr     = row_valid[previous_byte] ? ctr_rd[4:0] : 5'd0;
    cur_wrapped = row_valid[previous_byte] ? ctr_rd[5] : 1'b0;
    slot_ok     = cur_wrapped || (token[7:3] < cur_ctr);
  end

  always_comb begin
    emit_b    = token[8] ? token[7:0] : (zero_src ? 8'd0 : hist_rd);
    emit_done = ({1'b0, out_position} + 33'd1) >= {1'b0, output_size};
    emit_last = emit_done || (idx == len_m1);
  end

  // table and history memories
  always_ff @(posedge clk) begin
    if (state == clzss_pkg::ST_LOOKUP) begin
      ctr_rd <= ctr_mem[previous_byte];
      seq_rd <= seq_mem[{previous_byte, token[7:3]}];
    end
    if (state == clzss_pkg::ST_HREAD) begin
      hist_rd <= hist_mem[rd_ptr];
    end
    if (emit_fire) begin
      hist_mem[wr_ptr] <= emit_b;
    end
    if (state == clzss_pkg::ST_UPDATE) begin
      seq_mem[{previous_byte, ctr}] <= start_ptr;
      ctr_mem[previous_byte] <= {wrapped || (ctr == 5'h1F), ctr + 5'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= clzss_pkg::ST_IDLE;
      output_size   <= 32'd1;
      bit_buffer    <= '0;
      bit_count     <= '0;
      out_position  <= '0;
      previous_byte <= '0;
      finished      <= 1'b0;
      wr_ptr        <= '0;
      row_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        output_size <= cfg_wr_data;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        clzss_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (in_first) begin
              out_position  <= '0;
              previous_byte <= '0;
              finished      <= 1'b0;
              wr_ptr        <= '0;
              row_valid     <= '0;
            end
            if (base_fin) begin
              bit_buffer <= base_buf;
              bit_count  <= base_cnt;
            end else if (cnt_next < 5'd9) begin
              bit_buffer <= buf_next;
              bit_count  <= cnt_next;
            end else begin
              token      <= buf_next[8:0];
              bit_buffer <= buf_next >> 9;
              bit_count  <= cnt_next - 5'd9;
              state      <= clzss_pkg::ST_LOOKUP;
            end
          end
        end
        clzss_pkg::ST_LOOKUP: begin
          state <= clzss_pkg::ST_DECODE;
        end
        clzss_pkg::ST_DECODE: begin
          ctr       <= cur_ctr;
          wrapped   <= cur_wrapped;
          rd_ptr    <= slot_ok ? seq_rd : '0;
          zero_src  <= (out_position == 32'd0);
          start_ptr <= wr_ptr;
          idx       <= '0;
          len_m1    <= token[8] ? 3'd0 : token[2:0];
          if (out_position >= output_size) begin
            finished <= 1'b1;
            state    <= clzss_pkg::ST_IDLE;
          end else if (token[8]) begin
            state <= clzss_pkg::ST_EMIT;
          end else begin
            state <= clzss_pkg::ST_HREAD;
          end
        end
        clzss_pkg::ST_HREAD: begin
          state <= clzss_pkg::ST_EMIT;
        end
        clzss_pkg::ST_EMIT: begin
          if (emit_fire) begin
            out_byte     <= emit_b;
            out_last     <= emit_last;
            out_done     <= emit_done;
            last_b       <= emit_b;
            out_position <= out_position + 32'd1;
            wr_ptr       <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
            rd_ptr       <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
            idx          <= idx + 3'd1;
            if (emit_done) begin
              finished <= 1'b1;
              state    <= clzss_pkg::ST_IDLE;
            end else if (emit_last) begin
              state <= clzss_pkg::ST_UPDATE;
            end else begin
              state <= clzss_pkg::ST_HREAD;
            end
          end
        end
        clzss_pkg::ST_UPDATE: begin
          row_valid[previous_byte] <= 1'b1;
          previous_byte <= last_b;
          state         <= clzss_pkg::ST_IDLE;
        end
        default: begin
          state <= clzss_pkg::ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_fin_busy, clk, rst, (state != clzss_pkg::ST_IDLE) && finished, "busy while finished")
  `ASSERT_PROP(a_hread_emit, clk, rst, (state == clzss_pkg::ST_HREAD) |=> (state == clzss_pkg::ST_EMIT), "read not followed by emit")
  `ASSERT_PROP(a_done_last, clk, rst, (out_valid && out_done) |-> out_last, "done byte not marked last")

endmodule
